### rtl/pst_pkg.sv
// pst_pkg: shared types and constants for the prim spanning tree core
// used by pst_scan_unit and prim_spanning_tree_core; no dependencies
`default_nettype none

package pst_pkg;

  localparam int VERT_W      = 5;
  localparam int WEIGHT_W    = 16;
  localparam int ENTRY_W     = WEIGHT_W + 1;
  localparam int COUNT_W     = 6;
  localparam int MAX_RESULTS = 32;

  // candidates at or above this weight are never attached
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_LIMIT = 16'sd10000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETTLE,
    ST_ROOT,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_FINISH
  } pst_state_t;

  // sequencer to scan unit
  typedef struct packed {
    logic              init;
    logic [VERT_W-1:0] root;
    logic              begin_min;
    logic              step;
    logic [VERT_W-1:0] step_v;
    logic [VERT_W-1:0] src_u;
    logic              mark;
    logic [VERT_W-1:0] mark_v;
  } pst_scan_ctl_t;

  // scan unit to sequencer: cheapest attachment found in the last pass
  typedef struct packed {
    logic                       found;
    logic [VERT_W-1:0]          v;
    logic [VERT_W-1:0]          parent;
    logic signed [WEIGHT_W-1:0] w;
  } pst_pick_t;

endpackage

`default_nettype wire

### rtl/prim_spanning_tree_core.sv
// prim_spanning_tree_core: edge loader, Prim sequencer and result output
// depends on pst_pkg, pst_adj_ram and pst_scan_unit
// edges: one transaction per cycle while idle, result-free; busy stays high
// from the last edge through the build and the store clear.
// build: SETTLE and ROOT set up, then per tree vertex a SCAN of one adjacency row
// through the single read port, DRAIN and PICK; FINISH closes, then the same store clear.
// reset: synchronous, clears all 2**(2*clog2(VLIM)) store entries (1024 at
// 32 vertices) with busy high; results are strobes the receiver cannot stall
`default_nettype none

module prim_spanning_tree_core
  import pst_pkg::*;
#(
  parameter int NUM_VERTICES = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // edge transactions
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [VERT_W-1:0]          in_from_vertex,
  input  wire logic [VERT_W-1:0]          in_to_vertex,
  input  wire logic signed [WEIGHT_W-1:0] in_edge_weight,
  input  wire logic                       in_last_edge,
  // result transactions
  output logic                            out_valid,
  output logic [VERT_W-1:0]               out_vertex,
  output logic [VERT_W-1:0]               out_parent,
  output logic signed [WEIGHT_W-1:0]      out_weight,
  output logic                            out_is_root,
  output logic                            out_last,
  // start vertex register
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [VERT_W-1:0]          cfg_start_vertex
);

  localparam int VLIM  = (NUM_VERTICES < 32) ? NUM_VERTICES : 32;
  localparam int VBITS = (VLIM > 1) ? $clog2(VLIM) : 1;
  localparam int AW    = 2 * VBITS;
  localparam logic [VBITS-1:0] VLAST = VBITS'(VLIM - 1);

  pst_state_t state_r, state_nxt;

  logic [VERT_W-1:0]          start_vertex_r;

  // load stage
  logic                       ld_vld_r;
  logic                       ld_ok_r;
  logic [AW-1:0]              ld_addr_r;
  logic signed [WEIGHT_W-1:0] ld_w_r;
  logic                       lw_vld_r;
  logic [AW-1:0]              lw_addr_r;
  logic signed [WEIGHT_W-1:0] lw_w_r;
  logic                       cur_vld;
  logic signed [WEIGHT_W-1:0] cur_w;
  logic                       ld_wr;

  // sequencer registers
  logic [AW-1:0]              clr_cnt_r;
  logic [VBITS-1:0]           u_r;
  logic [VBITS-1:0]           vcnt_r;
  logic                       scan_vld_r;
  logic [VBITS-1:0]           scan_v_r;
  logic [COUNT_W-1:0]         n_r;
  logic [VERT_W-1:0]          pend_v_r;
  logic [VERT_W-1:0]          pend_p_r;
  logic signed [WEIGHT_W-1:0] pend_w_r;
  logic                       pend_root_r;

  // output registers
  logic                       out_valid_r;
  logic [VERT_W-1:0]          out_vertex_r;
  logic [VERT_W-1:0]          out_parent_r;
  logic signed [WEIGHT_W-1:0] out_weight_r;
  logic                       out_is_root_r;
  logic                       out_last_r;

  // store ports
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [ENTRY_W-1:0]         wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [ENTRY_W-1:0]         rd_data;

  pst_scan_ctl_t              ctl;
  pst_pick_t                  pick;

  logic                       accept;
  logic                       in_ok;
  logic [AW-1:0]              in_addr;
  logic                       root_ok;
  logic                       take;
  logic                       emit;
  logic                       emit_last;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign in_ok   = ({1'b0, in_from_vertex} < 6'(VLIM)) && ({1'b0, in_to_vertex} < 6'(VLIM));
  assign in_addr = {in_from_vertex[VBITS-1:0], in_to_vertex[VBITS-1:0]};
  assign root_ok = ({1'b0, start_vertex_r} < 6'(VLIM));
  assign take    = pick.found && (n_r < COUNT_W'(MAX_RESULTS));

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_vertex_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_vertex_r <= cfg_start_vertex;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept && in_last_edge) state_nxt = ST_SETTLE;
      ST_SETTLE: state_nxt = ST_ROOT;
      ST_ROOT:   state_nxt = root_ok ? ST_SCAN : ST_FINISH;
      ST_SCAN:   if (vcnt_r == VLAST) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_PICK;
      ST_PICK:   state_nxt = take ? ST_SCAN : ST_FINISH;
      ST_FINISH: state_nxt = ST_CLEAR;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // load compare, forwarding the write made at the previous edge
  always_comb begin
    if (lw_vld_r && (lw_addr_r == ld_addr_r)) begin
      cur_vld = 1'b1;
      cur_w = lw_w_r;
    end else begin
      cur_vld = rd_data[ENTRY_W-1];
      cur_w = $signed(rd_data[WEIGHT_W-1:0]);
    end
    ld_wr = ld_vld_r && ld_ok_r && (!cur_vld || (ld_w_r < cur_w));
  end

  // sequencer outputs
  always_comb begin
    wr_en = 1'b0;
    wr_addr = ld_addr_r;
    wr_data = {1'b1, ld_w_r};
    rd_en = 1'b0;
    rd_addr = in_addr;
    emit = 1'b0;
    emit_last = 1'b0;
    ctl = '0;
    ctl.root = start_vertex_r;
    ctl.step = scan_vld_r;
    ctl.step_v = VERT_W'(scan_v_r);
    ctl.src_u = VERT_W'(u_r);
    ctl.mark_v = pick.v;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
      end
      ST_IDLE, ST_SETTLE: begin
        wr_en = ld_wr;
        rd_en = accept;
      end
      ST_ROOT: begin
        ctl.init = 1'b1;
        ctl.begin_min = 1'b1;
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        rd_addr = {u_r, vcnt_r};
      end
      ST_DRAIN: begin
      end
      ST_PICK: begin
        ctl.begin_min = 1'b1;
        ctl.mark = take;
        emit = take;
      end
      ST_FINISH: begin
        emit = 1'b1;
        emit_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // load pipeline and last-write record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_vld_r <= 1'b0;
      lw_vld_r <= 1'b0;
    end else begin
      ld_vld_r <= accept;
      lw_vld_r <= ld_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_ok_r <= in_ok;
      ld_addr_r <= in_addr;
      ld_w_r <= in_edge_weight;
    end
    lw_addr_r <= ld_addr_r;
    lw_w_r <= ld_w_r;
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (state_r == ST_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end else begin
      clr_cnt_r <= '0;
    end
  end

  // scan counters and row source
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= '0;
      scan_vld_r <= 1'b0;
      n_r <= '0;
    end else begin
      scan_vld_r <= (state_r == ST_SCAN);
      if (state_r == ST_SCAN) begin
        vcnt_r <= vcnt_r + VBITS'(1);
      end else begin
        vcnt_r <= '0;
      end
      if (state_r == ST_ROOT) begin
        n_r <= COUNT_W'(1);
      end else if ((state_r == ST_PICK) && take) begin
        n_r <= n_r + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_v_r <= vcnt_r;
    if (state_r == ST_ROOT) begin
      u_r <= start_vertex_r[VBITS-1:0];
    end else if ((state_r == ST_PICK) && take) begin
      u_r <= pick.v[VBITS-1:0];
    end
  end

  // pending result, held until the next one or the end is known
  always_ff @(posedge clk) begin
    if (state_r == ST_ROOT) begin
      pend_v_r <= start_vertex_r;
      pend_p_r <= '0;
      pend_w_r <= '0;
      pend_root_r <= 1'b1;
    end else if ((state_r == ST_PICK) && take) begin
      pend_v_r <= pick.v;
      pend_p_r <= pick.parent;
      pend_w_r <= pick.w;
      pend_root_r <= 1'b0;
    end
  end

  // result strobe and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_vertex_r <= pend_v_r;
      out_parent_r <= pend_p_r;
      out_weight_r <= pend_w_r;
      out_is_root_r <= pend_root_r;
      out_last_r <= emit_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_vertex  = out_vertex_r;
  assign out_parent  = out_parent_r;
  assign out_weight  = out_weight_r;
  assign out_is_root = out_is_root_r;
  assign out_last    = out_last_r;

  pst_adj_ram #(
    .AW (AW),
    .DW (ENTRY_W)
  ) u_adj_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pst_scan_unit #(
    .VLIM  (VLIM),
    .VBITS (VBITS)
  ) u_scan_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .ent_vld (rd_data[ENTRY_W-1]),
    .ent_w   ($signed(rd_data[WEIGHT_W-1:0])),
    .pick    (pick)
  );

endmodule

`default_nettype wire

### rtl/pst_adj_ram.sv
// pst_adj_ram: adjacency store, one write port and one registered read port
// each entry holds a valid bit over a signed weight; no dependencies
`default_nettype none

module pst_adj_ram #(
  parameter int AW = 10,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/pst_scan_unit.sv
// pst_scan_unit: shared relax and compare unit with per-vertex tree state
// depends on pst_pkg; driven one vertex per cycle by the sequencer during each scan pass
`default_nettype none

module pst_scan_unit
  import pst_pkg::*;
#(
  parameter int VLIM  = 32,
  parameter int VBITS = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pst_scan_ctl_t              ctl,
  input  wire logic                       ent_vld,
  input  wire logic signed [WEIGHT_W-1:0] ent_w,
  output pst_pick_t                       pick
);

  logic [VLIM-1:0]            in_tree_r;
  logic [VLIM-1:0]            known_r;
  logic signed [WEIGHT_W-1:0] best_w_r [VLIM];
  logic [VBITS-1:0]           best_p_r [VLIM];

  logic                       min_found_r;
  logic [VBITS-1:0]           min_v_r;
  logic [VBITS-1:0]           min_p_r;
  logic signed [WEIGHT_W-1:0] min_w_r;

  logic [VBITS-1:0]           vd;
  logic [VBITS-1:0]           src;
  logic [VBITS-1:0]           root;
  logic [VBITS-1:0]           mark_idx;
  logic                       tree;
  logic                       known;
  logic signed [WEIGHT_W-1:0] bw;
  logic [VBITS-1:0]           bp;
  logic                       upd;
  logic signed [WEIGHT_W-1:0] nw;
  logic [VBITS-1:0]           np;
  logic                       nk;
  logic signed [WEIGHT_W-1:0] lim;
  logic                       cand;

  assign vd       = ctl.step_v[VBITS-1:0];
  assign src      = ctl.src_u[VBITS-1:0];
  assign root     = ctl.root[VBITS-1:0];
  assign mark_idx = ctl.mark_v[VBITS-1:0];

  // relax the edge from the current source into vertex vd
  always_comb begin
    tree = in_tree_r[vd];
    known = known_r[vd];
    bw = best_w_r[vd];
    bp = best_p_r[vd];
    upd = !tree && ent_vld && (!known || (ent_w < bw));
    nw = upd ? ent_w : bw;
    np = upd ? src : bp;
    nk = known || upd;
  end

  // running minimum, strict compare keeps the lowest vertex on ties
  always_comb begin
    lim = min_found_r ? min_w_r : WEIGHT_LIMIT;
    cand = !tree && nk && (nw < lim);
  end

  // tree membership and known flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_tree_r <= '0;
      known_r <= '0;
    end else if (ctl.init) begin
      for (int i = 0; i < VLIM; i++) begin
        in_tree_r[i] <= (VBITS'(i) == root);
      end
      known_r <= '0;
    end else begin
      if (ctl.step && upd) begin
        known_r[vd] <= 1'b1;
      end
      if (ctl.mark) begin
        in_tree_r[mark_idx] <= 1'b1;
      end
    end
  end

  // best attachment per vertex
  always_ff @(posedge clk) begin
    if (ctl.step && upd) begin
      best_w_r[vd] <= ent_w;
      best_p_r[vd] <= src;
    end
  end

  // minimum over the pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_found_r <= 1'b0;
    end else if (ctl.begin_min) begin
      min_found_r <= 1'b0;
    end else if (ctl.step && cand) begin
      min_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && cand) begin
      min_v_r <= vd;
      min_p_r <= np;
      min_w_r <= nw;
    end
  end

  assign pick.found  = min_found_r;
  assign pick.v      = VERT_W'(min_v_r);
  assign pick.parent = VERT_W'(min_p_r);
  assign pick.w      = min_w_r;

endmodule

`default_nettype wire

### tb/prim_spanning_tree_core_tb.sv
// prim_spanning_tree_core_tb: self-checking bench for the prim spanning tree core
// depends on pst_pkg and prim_spanning_tree_core; edges go in as start/busy
// transactions, tree results are checked against an in-bench prim predictor
`timescale 1ns / 100ps

module prim_spanning_tree_core_tb;
  import pst_pkg::*;

  localparam int NUM_V       = 32;
  localparam int ITEMS_TOTAL = 310;

  // stimulus row kinds and random graph shapes
  localparam logic ROW_EDGE     = 1'b0;
  localparam logic ROW_CFG      = 1'b1;
  localparam int   GRAPH_NOISE  = 0;
  localparam int   GRAPH_FULL   = 1;
  localparam int   GRAPH_SPARSE = 2;

  typedef struct packed {
    logic [VERT_W-1:0]          vertex;
    logic [VERT_W-1:0]          parent;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       is_root;
    logic                       last;
  } tree_res_t;

  typedef struct packed {
    logic                       kind;
    logic [VERT_W-1:0]          src;
    logic [VERT_W-1:0]          dst;
    logic signed [WEIGHT_W-1:0] w;
    logic                       last_e;
    logic [1:0]                 n_typed;
    tree_res_t                  t0;
    tree_res_t                  t1;
  } dir_row_t;

  typedef struct packed {
    logic [VERT_W-1:0]          src;
    logic [VERT_W-1:0]          dst;
    logic signed [WEIGHT_W-1:0] w;
  } link_t;

  localparam tree_res_t NO_RES   = '0;
  localparam int        DIR_ROWS = 21;

  // directed part; typed results only where they are obvious
  dir_row_t dir_table [DIR_ROWS] = '{
    // self loop from the reset start vertex: root alone
    '{ROW_EDGE, 0, 0, 5, 1, 1, '{0, 0, 0, 1, 1}, NO_RES},
    // most negative weight to the top vertex
    '{ROW_EDGE, 0, 31, -32768, 1, 2, '{0, 0, 0, 1, 0}, '{31, 0, -32768, 0, 1}},
    // weight at the limit is never taken
    '{ROW_EDGE, 0, 1, 10000, 1, 1, '{0, 0, 0, 1, 1}, NO_RES},
    // one below the limit is taken
    '{ROW_EDGE, 0, 1, 9999, 1, 2, '{0, 0, 0, 1, 0}, '{1, 0, 9999, 0, 1}},
    '{ROW_CFG, 31, 0, 0, 0, 0, NO_RES, NO_RES},
    // repeated edge keeps the smaller weight, ties by destination then by source age
    '{ROW_EDGE, 31, 30, 7, 0, 0, NO_RES, NO_RES},
    '{ROW_EDGE, 31, 30, 3, 0, 0, NO_RES, NO_RES},
    '{ROW_EDGE, 31, 30, 9, 0, 0, NO_RES, NO_RES},
    '{ROW_EDGE, 31, 5, 3, 0, 0, NO_RES, NO_RES},
    '{ROW_EDGE, 31, 4, 3, 0, 0, NO_RES, NO_RES},
    '{ROW_EDGE, 4, 5, 3, 0, 0, NO_RES, NO_RES},
    '{ROW_EDGE, 5, 6, -1, 0, 0, NO_RES, NO_RES},
    '{ROW_EDGE, 6, 31, -5, 0, 0, NO_RES, NO_RES},
    '{ROW_EDGE, 30, 0, 32767, 0, 0, NO_RES, NO_RES},
    '{ROW_EDGE, 6, 7, 0, 1, 0, NO_RES, NO_RES},
    // start vertex with no outgoing edges
    '{ROW_CFG, 17, 0, 0, 0, 0, NO_RES, NO_RES},
    '{ROW_EDGE, 3, 4, 1, 1, 1, '{17, 0, 0, 1, 1}, NO_RES},
    '{ROW_CFG, 0, 0, 0, 0, 0, NO_RES, NO_RES},
    // only an incoming edge and a heavy one at the root
    '{ROW_EDGE, 31, 31, 32767, 0, 0, NO_RES, NO_RES},
    '{ROW_EDGE, 2, 0, -1, 0, 0, NO_RES, NO_RES},
    '{ROW_EDGE, 0, 2, 32767, 1, 1, '{0, 0, 0, 1, 1}, NO_RES}
  };

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [VERT_W-1:0]          in_from_vertex;
  logic [VERT_W-1:0]          in_to_vertex;
  logic signed [WEIGHT_W-1:0] in_edge_weight;
  logic                       in_last_edge;
  logic                       out_valid;
  logic [VERT_W-1:0]          out_vertex;
  logic [VERT_W-1:0]          out_parent;
  logic signed [WEIGHT_W-1:0] out_weight;
  logic                       out_is_root;
  logic                       out_last;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [VERT_W-1:0]          cfg_start_vertex;

  // predictor state: adjacency store, tree membership, cheapest attachments
  logic                       link_ok  [NUM_V][NUM_V];
  logic signed [WEIGHT_W-1:0] link_w   [NUM_V][NUM_V];
  logic                       joined   [NUM_V];
  logic                       reached  [NUM_V];
  logic signed [WEIGHT_W-1:0] cand_w   [NUM_V];
  logic [VERT_W-1:0]          cand_src [NUM_V];
  logic [VERT_W-1:0]          root_cfg;

  tree_res_t tree_expect [$];
  int        items_sent;
  int        builds_done;
  int        results_checked;
  int        fail_count;

  prim_spanning_tree_core #(
    .NUM_VERTICES(NUM_V)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_from_vertex   (in_from_vertex),
    .in_to_vertex     (in_to_vertex),
    .in_edge_weight   (in_edge_weight),
    .in_last_edge     (in_last_edge),
    .out_valid        (out_valid),
    .out_vertex       (out_vertex),
    .out_parent       (out_parent),
    .out_weight       (out_weight),
    .out_is_root      (out_is_root),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_start_vertex (cfg_start_vertex)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void clear_links();
    for (int a = 0; a < NUM_V; a++) begin
      joined[a] = 1'b0;
      for (int b = 0; b < NUM_V; b++) begin
        link_ok[a][b] = 1'b0;
        link_w[a][b]  = '0;
      end
    end
  endfunction

  // a repeated edge only lowers the stored weight
  function automatic void store_link(logic [VERT_W-1:0] f, logic [VERT_W-1:0] t,
                                     logic signed [WEIGHT_W-1:0] w);
    if (!link_ok[f][t] || w < link_w[f][t]) begin
      link_ok[f][t] = 1'b1;
      link_w[f][t]  = w;
    end
  endfunction

  // strictly smaller weights only, so earlier tree vertices keep ties
  function automatic void offer_links(int u);
    for (int v = 0; v < NUM_V; v++) begin
      if (!joined[v] && link_ok[u][v] && (!reached[v] || link_w[u][v] < cand_w[v])) begin
        reached[v]  = 1'b1;
        cand_w[v]   = link_w[u][v];
        cand_src[v] = VERT_W'(u);
      end
    end
  endfunction

  // grow the tree from the configured root, then empty the store
  function automatic void grow_tree(output tree_res_t got [$]);
    tree_res_t r;
    int        lim;
    int        pick;
    bit        found;
    got = {};
    r = '{vertex: root_cfg, parent: '0, weight: '0, is_root: 1'b1, last: 1'b0};
    got = {got, r};
    for (int v = 0; v < NUM_V; v++) begin
      joined[v]  = 1'b0;
      reached[v] = 1'b0;
    end
    joined[root_cfg] = 1'b1;
    offer_links(int'(root_cfg));
    while (got.size() < MAX_RESULTS) begin
      found = 1'b0;
      lim   = int'(WEIGHT_LIMIT);
      pick  = 0;
      // lowest vertex wins among equal weights
      for (int v = 0; v < NUM_V; v++) begin
        if (!joined[v] && reached[v] && int'(cand_w[v]) < lim) begin
          lim   = int'(cand_w[v]);
          pick  = v;
          found = 1'b1;
        end
      end
      if (!found) break;
      joined[pick] = 1'b1;
      r = '{vertex: VERT_W'(pick), parent: cand_src[pick], weight: cand_w[pick],
            is_root: 1'b0, last: 1'b0};
      got = {got, r};
      offer_links(pick);
    end
    got[got.size()-1].last = 1'b1;
    clear_links();
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endfunction

  // result transactions are taken at the edge that ends their strobe cycle
  always @(posedge clk) begin
    tree_res_t want;
    if (rst_n && out_valid) begin
      if (tree_expect.size() == 0) begin
        $error("unexpected result transaction: vertex %0d parent %0d", out_vertex, out_parent);
        fail_count++;
      end else begin
        want = tree_expect.pop_front();
        check_field("vertex", 32'(want.vertex), 32'(out_vertex));
        check_field("parent", 32'(want.parent), 32'(out_parent));
        check_field("weight", 32'(want.weight), 32'(out_weight));
        check_field("is_root", 32'(want.is_root), 32'(out_is_root));
        check_field("last", 32'(want.last), 32'(out_last));
        results_checked++;
      end
    end
  end

  // one edge transaction; start is left high so back-to-back items need no gap
  task automatic send_edge(logic [VERT_W-1:0] f, logic [VERT_W-1:0] t,
                           logic signed [WEIGHT_W-1:0] w, logic last_e,
                           logic [1:0] n_typed, tree_res_t t0, tree_res_t t1);
    tree_res_t got [$];
    bit        quiet;
    quiet = (items_sent >= 120 && items_sent < 200);
    if (!quiet && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start          <= 1'b1;
    in_from_vertex <= f;
    in_to_vertex   <= t;
    in_edge_weight <= w;
    in_last_edge   <= last_e;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    store_link(f, t, w);
    if (last_e) begin
      grow_tree(got);
      builds_done++;
      if (n_typed == 2'd0) begin
        tree_expect = {tree_expect, got};
      end else begin
        tree_expect = {tree_expect, t0};
        if (n_typed > 2'd1) tree_expect = {tree_expect, t1};
      end
    end
  endtask

  // hold off until every result is in and the store clear is done
  task automatic drain_results();
    start <= 1'b0;
    while (tree_expect.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start(logic [VERT_W-1:0] v);
    drain_results();
    cfg_valid        <= 1'b1;
    cfg_start_vertex <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    root_cfg = v;
  endtask

  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return WEIGHT_W'($urandom);
      1: return WEIGHT_W'($urandom_range(10000, 32767));
      2: return WEIGHT_W'($urandom_range(9998, 10001));
      default: return WEIGHT_W'(int'($urandom_range(0, 16)) - 8);
    endcase
  endfunction

  // one graph: edges reachable from the root (or noise), last edge starts the build
  task automatic run_graph(int shape);
    link_t             links [$];
    logic [VERT_W-1:0] verts [$];
    logic [NUM_V-1:0]  used;
    logic [VERT_W-1:0] order [NUM_V];
    logic [VERT_W-1:0] tmp;
    link_t             l;
    int                k;
    int                j;
    links = {};
    case (shape)
      GRAPH_NOISE: begin
        repeat ($urandom_range(1, 12)) begin
          l = '{src: VERT_W'($urandom), dst: VERT_W'($urandom), w: WEIGHT_W'($urandom)};
          links = {links, l};
        end
      end
      GRAPH_FULL: begin
        // random spanning tree over every vertex, rooted at the start vertex
        for (int i = 0; i < NUM_V; i++) order[i] = VERT_W'(i);
        order[root_cfg] = order[0];
        order[0]        = root_cfg;
        for (int i = NUM_V - 1; i >= 2; i--) begin
          j        = $urandom_range(1, i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 1; i < NUM_V; i++) begin
          l = '{src: order[$urandom_range(0, i - 1)], dst: order[i],
                w: WEIGHT_W'(int'($urandom_range(0, 40)) - 20)};
          links = {links, l};
        end
      end
      default: begin
        k     = $urandom_range(2, 8);
        used  = '0;
        verts = {};
        verts = {verts, root_cfg};
        used[root_cfg] = 1'b1;
        while (verts.size() < k) begin
          tmp = VERT_W'($urandom);
          if (!used[tmp]) begin
            used[tmp] = 1'b1;
            verts = {verts, tmp};
          end
        end
        for (int i = 1; i < k; i++) begin
          l = '{src: verts[$urandom_range(0, i - 1)], dst: verts[i], w: pick_weight()};
          links = {links, l};
        end
        repeat ($urandom_range(0, k)) begin
          l = '{src: verts[$urandom_range(0, k - 1)], dst: verts[$urandom_range(0, k - 1)],
                w: pick_weight()};
          links = {links, l};
        end
      end
    endcase
    foreach (links[i]) begin
      send_edge(links[i].src, links[i].dst, links[i].w, i == links.size() - 1,
                2'd0, NO_RES, NO_RES);
    end
  endtask

  // main sequence
  initial begin
    int r;
    int wait_cycles;
    items_sent       = 0;
    builds_done      = 0;
    results_checked  = 0;
    fail_count       = 0;
    root_cfg         = '0;
    clear_links();
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_from_vertex   <= '0;
    in_to_vertex     <= '0;
    in_edge_weight   <= '0;
    in_last_edge     <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_start_vertex <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].kind == ROW_CFG) begin
        write_start(dir_table[i].src);
      end else begin
        send_edge(dir_table[i].src, dir_table[i].dst, dir_table[i].w, dir_table[i].last_e,
                  dir_table[i].n_typed, dir_table[i].t0, dir_table[i].t1);
      end
    end

    // random graphs, the first one spanning every vertex
    run_graph(GRAPH_FULL);
    while (items_sent < ITEMS_TOTAL) begin
      r = $urandom_range(0, 5);
      if (r == 0) write_start(VERT_W'($urandom));
      else if (r == 1) write_start($urandom_range(0, 1) ? VERT_W'(NUM_V - 1) : '0);
      else if (r == 2) drain_results();
      r = $urandom_range(0, 19);
      if (r < 3) run_graph(GRAPH_NOISE);
      else if (r == 3) run_graph(GRAPH_FULL);
      else run_graph(GRAPH_SPARSE);
    end

    // wind down, bounded
    start <= 1'b0;
    wait_cycles = 0;
    while (tree_expect.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (tree_expect.size() != 0) begin
      $error("%0d expected results never arrived", tree_expect.size());
      fail_count++;
    end
    wait_cycles = 0;
    while (busy && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);

    $display("covered %0d edge transactions and %0d tree builds, %0d results checked",
             items_sent, builds_done, results_checked);
    if (fail_count == 0) begin
      $display("prim_spanning_tree_core: match");
    end else begin
      $display("prim_spanning_tree_core: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("prim_spanning_tree_core: mismatch");
    $finish;
  end

endmodule
